/* hw/rtl/tlv_pkg.sv */
// Shared types and constants for the TLV frame validator.
// Used by tlv_front, tlv_queue, tlv_back and tlv_frame_validator.
package tlv_pkg;

    localparam int unsigned LENGTH_BITS_DEFAULT = 20;
    localparam int unsigned MAX_FIELDS          = 15;
    localparam int unsigned HDR_SIZE            = 12;
    localparam int unsigned FHDR_SIZE           = 5;
    localparam int unsigned QUEUE_DEPTH         = 4;

    localparam logic [7:0] CFG_VERSION_RST = 8'd1;
    localparam logic [7:0] CFG_KIND_RST    = 8'd1;
    localparam logic [3:0] CFG_FIELDS_RST  = 4'd6;
    localparam int unsigned CFG_MAX_RST    = 4096;

    typedef enum logic [1:0] {
        CFG_VERSION  = 2'd0,
        CFG_KIND     = 2'd1,
        CFG_FIELDS   = 2'd2,
        CFG_MAX_SIZE = 2'd3
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_TRUNC     = 4'd1,
        ST_OVERSIZED = 4'd2,
        ST_MAGIC     = 4'd3,
        ST_VERSION   = 4'd4,
        ST_KIND      = 4'd5,
        ST_COUNT     = 4'd6,
        ST_BODY_SIZE = 4'd7,
        ST_DUPLICATE = 4'd8,
        ST_ORDER     = 4'd9,
        ST_UNKNOWN   = 4'd10,
        ST_FIELD_SET = 4'd11
    } status_t;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_FHDR   = 2'd1,
        PH_VALUE  = 2'd2,
        PH_IDLE   = 2'd3
    } phase_t;

    // Control part of one queued entry: a descriptor, a status, or both.
    typedef struct packed {
        logic       has_desc;
        logic       has_status;
        status_t    code;
        logic [3:0] idx;
        logic [7:0] tag;
    } tlv_ctl_t;

    function automatic logic [7:0] magic_byte(input logic [1:0] pos);
        logic [7:0] b;
        case (pos)
            2'd0:    b = 8'h4C;
            2'd1:    b = 8'h4B;
            2'd2:    b = 8'h52;
            default: b = 8'h32;
        endcase
        return b;
    endfunction

endpackage

/* hw/rtl/tlv_frame_validator.sv */
// Top level of the TLV frame validator: parser, entry queue and output stage.
// Depends on tlv_pkg, tlv_front, tlv_queue and tlv_back.
//
//  channel  | ports                                   | direction | beat
//  ---------+-----------------------------------------+-----------+---------------------
//  s_       | s_valid/s_ready, data_byte, frame_end   | in        | one frame byte
//  m_       | m_valid/m_ready, is_status .. length    | out       | descriptor or status
//  cfg_     | cfg_valid/cfg_ready, cfg_index, cfg_data| in        | one register write
//
// Throughput: one byte per cycle while the queue is not full; each byte is parsed in the cycle it is accepted.
// A byte that yields a descriptor and a status gives two output beats; the
// four-entry queue between parser and output register absorbs these.
// Reset: synchronous, active low; config returns to defaults, no clearing pass.
// Stalls: s_ready drops only while the queue is full; cfg_ready is always high.
module tlv_frame_validator #(
    parameter int unsigned LENGTH_BITS = tlv_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_data_byte,
    input  logic                   s_frame_end,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_is_status,
    output logic [3:0]             m_status,
    output logic [3:0]             m_field_index,
    output logic [7:0]             m_field_tag,
    output logic [LENGTH_BITS-1:0] m_value_offset,
    output logic [LENGTH_BITS-1:0] m_value_length,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [1:0]             cfg_index,
    input  logic [LENGTH_BITS-1:0] cfg_data
);
    import tlv_pkg::*;

    localparam int unsigned CTL_W = $bits(tlv_ctl_t);
    localparam int unsigned ENT_W = CTL_W + 2 * LENGTH_BITS;

    logic                   q_full;
    logic                   q_push;
    logic                   q_pop;
    logic                   q_valid;
    tlv_ctl_t               ent_ctl;
    logic [LENGTH_BITS-1:0] ent_off;
    logic [LENGTH_BITS-1:0] ent_len;
    logic [ENT_W-1:0]       q_data;
    tlv_ctl_t               q_ctl;
    logic [LENGTH_BITS-1:0] q_off;
    logic [LENGTH_BITS-1:0] q_len;

    tlv_front #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_frame_end (s_frame_end),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_full      (q_full),
        .q_push      (q_push),
        .ent_ctl     (ent_ctl),
        .ent_off     (ent_off),
        .ent_len     (ent_len)
    );

    tlv_queue #(
        .WIDTH(ENT_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data ({ent_ctl, ent_off, ent_len}),
        .full      (q_full),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .q_data    (q_data)
    );

    assign q_ctl = tlv_ctl_t'(q_data[ENT_W-1 -: CTL_W]);
    assign q_off = q_data[2*LENGTH_BITS-1 -: LENGTH_BITS];
    assign q_len = q_data[LENGTH_BITS-1:0];

    tlv_back #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_ctl          (q_ctl),
        .q_off          (q_off),
        .q_len          (q_len),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_is_status    (m_is_status),
        .m_status       (m_status),
        .m_field_index  (m_field_index),
        .m_field_tag    (m_field_tag),
        .m_value_offset (m_value_offset),
        .m_value_length (m_value_length)
    );

endmodule

/* hw/rtl/tlv_front.sv */
// Front end: configuration registers and the per-byte frame parser.
// Emits one queue entry per byte that yields a descriptor and/or a status. Uses tlv_pkg.
module tlv_front #(
    parameter int unsigned LENGTH_BITS = tlv_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_data_byte,
    input  logic                   s_frame_end,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [1:0]             cfg_index,
    input  logic [LENGTH_BITS-1:0] cfg_data,
    input  logic                   q_full,
    output logic                   q_push,
    output tlv_pkg::tlv_ctl_t      ent_ctl,
    output logic [LENGTH_BITS-1:0] ent_off,
    output logic [LENGTH_BITS-1:0] ent_len
);
    import tlv_pkg::*;

    localparam int unsigned BC_W = LENGTH_BITS + 1;

    logic [7:0]             version_reg;
    logic [7:0]             kind_reg;
    logic [3:0]             fields_reg;
    logic [LENGTH_BITS-1:0] max_size_reg;

    logic [BC_W-1:0]        byte_count_reg, byte_count_next;
    phase_t                 phase_reg, phase_next;
    logic [2:0]             hdr_flags_reg, hdr_flags_next;
    logic [15:0]            count_word_reg, count_word_next;
    logic [31:0]            body_word_reg, body_word_next;
    logic [3:0]             field_num_reg, field_num_next;
    logic [7:0]             prev_tag_reg, prev_tag_next;
    logic [2:0]             fhb_reg, fhb_next;
    logic [31:0]            length_word_reg, length_word_next;
    logic [LENGTH_BITS-1:0] value_left_reg, value_left_next;
    status_t                field_err_reg, field_err_next;
    logic                   set_mis_reg, set_mis_next;
    logic                   trailing_reg, trailing_next;
    logic [7:0]             cur_tag_reg, cur_tag_next;

    logic                   acc;
    logic                   sat;
    logic [BC_W-1:0]        max_ext;
    logic [BC_W-1:0]        bc_inc;
    logic [BC_W-1:0]        pos_m11;
    logic [3:0]             fw;
    logic [3:0]             fn_inc;
    logic [2:0]             fhb_inc;
    logic [31:0]            len_new;
    status_t                code;
    status_t                fin;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_full;
    assign acc       = s_valid && s_ready;

    assign max_ext = {1'b0, max_size_reg};
    assign sat     = byte_count_reg >= max_ext;
    assign bc_inc  = byte_count_reg + BC_W'(1);
    assign pos_m11 = byte_count_reg - BC_W'(HDR_SIZE - 1);
    assign fw      = (32'(fields_reg) > MAX_FIELDS) ? 4'(MAX_FIELDS) : fields_reg;
    assign fn_inc  = field_num_reg + 4'd1;
    assign fhb_inc = fhb_reg + 3'd1;
    assign len_new = {length_word_reg[23:0], s_data_byte};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            version_reg  <= CFG_VERSION_RST;
            kind_reg     <= CFG_KIND_RST;
            fields_reg   <= CFG_FIELDS_RST;
            max_size_reg <= LENGTH_BITS'(CFG_MAX_RST);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                CFG_VERSION:  version_reg  <= cfg_data[7:0];
                CFG_KIND:     kind_reg     <= cfg_data[7:0];
                CFG_FIELDS:   fields_reg   <= cfg_data[3:0];
                CFG_MAX_SIZE: max_size_reg <= cfg_data;
                default:      version_reg  <= version_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg  <= '0;
            phase_reg       <= PH_HEADER;
            hdr_flags_reg   <= '0;
            count_word_reg  <= '0;
            body_word_reg   <= '0;
            field_num_reg   <= '0;
            prev_tag_reg    <= '0;
            fhb_reg         <= '0;
            length_word_reg <= '0;
            value_left_reg  <= '0;
            field_err_reg   <= ST_OK;
            set_mis_reg     <= 1'b0;
            trailing_reg    <= 1'b0;
            cur_tag_reg     <= '0;
        end else begin
            byte_count_reg  <= byte_count_next;
            phase_reg       <= phase_next;
            hdr_flags_reg   <= hdr_flags_next;
            count_word_reg  <= count_word_next;
            body_word_reg   <= body_word_next;
            field_num_reg   <= field_num_next;
            prev_tag_reg    <= prev_tag_next;
            fhb_reg         <= fhb_next;
            length_word_reg <= length_word_next;
            value_left_reg  <= value_left_next;
            field_err_reg   <= field_err_next;
            set_mis_reg     <= set_mis_next;
            trailing_reg    <= trailing_next;
            cur_tag_reg     <= cur_tag_next;
        end
    end

    always_comb begin
        byte_count_next  = byte_count_reg;
        phase_next       = phase_reg;
        hdr_flags_next   = hdr_flags_reg;
        count_word_next  = count_word_reg;
        body_word_next   = body_word_reg;
        field_num_next   = field_num_reg;
        prev_tag_next    = prev_tag_reg;
        fhb_next         = fhb_reg;
        length_word_next = length_word_reg;
        value_left_next  = value_left_reg;
        field_err_next   = field_err_reg;
        set_mis_next     = set_mis_reg;
        trailing_next    = trailing_reg;
        cur_tag_next     = cur_tag_reg;
        code             = ST_OK;
        fin              = ST_OK;
        ent_ctl          = '0;
        ent_off          = '0;
        ent_len          = '0;

        if (acc) begin
            if (sat) begin
                // hold the count one past the limit; drop the byte
                byte_count_next = max_ext + BC_W'(1);
            end else begin
                byte_count_next = bc_inc;
                case (phase_reg)
                    PH_HEADER: begin
                        if (byte_count_reg < BC_W'(4)) begin
                            if (s_data_byte != magic_byte(byte_count_reg[1:0]))
                                hdr_flags_next[0] = 1'b1;
                        end else if (byte_count_reg == BC_W'(4)) begin
                            if (s_data_byte != version_reg) hdr_flags_next[1] = 1'b1;
                        end else if (byte_count_reg == BC_W'(5)) begin
                            if (s_data_byte != kind_reg) hdr_flags_next[2] = 1'b1;
                        end else if (byte_count_reg < BC_W'(8)) begin
                            count_word_next = {count_word_reg[7:0], s_data_byte};
                        end else begin
                            body_word_next = {body_word_reg[23:0], s_data_byte};
                        end
                        if (byte_count_reg >= BC_W'(HDR_SIZE - 1)) begin
                            fhb_next   = '0;
                            phase_next = (fw == 4'd0) ? PH_IDLE : PH_FHDR;
                        end
                    end
                    PH_FHDR: begin
                        if (fhb_reg == 3'd0) begin
                            cur_tag_next     = s_data_byte;
                            length_word_next = '0;
                        end else begin
                            length_word_next = len_new;
                        end
                        fhb_next = fhb_inc;
                        if (fhb_inc >= 3'(FHDR_SIZE)) begin
                            fhb_next = '0;
                            if (field_num_reg != 4'd0 && cur_tag_reg == prev_tag_reg) begin
                                code = ST_DUPLICATE;
                            end else if (field_num_reg != 4'd0
                                         && cur_tag_reg < prev_tag_reg) begin
                                code = ST_ORDER;
                            end else if (cur_tag_reg == 8'd0
                                         || cur_tag_reg > {4'd0, fw}) begin
                                code = ST_UNKNOWN;
                            end else begin
                                if (cur_tag_reg != {4'd0, fn_inc}) set_mis_next = 1'b1;
                                if (len_new > 32'(max_size_reg)) code = ST_OVERSIZED;
                            end
                            if (code != ST_OK) begin
                                field_err_next = code;
                                phase_next     = PH_IDLE;
                            end else begin
                                prev_tag_next = cur_tag_reg;
                                if (hdr_flags_reg == 3'd0
                                    && count_word_reg == 16'(fields_reg)) begin
                                    ent_ctl.has_desc = 1'b1;
                                    ent_ctl.idx      = field_num_reg;
                                    ent_ctl.tag      = cur_tag_reg;
                                    ent_off          = bc_inc[LENGTH_BITS-1:0];
                                    ent_len          = len_new[LENGTH_BITS-1:0];
                                end
                                if (len_new == 32'd0) begin
                                    field_num_next = fn_inc;
                                    phase_next     = (fn_inc >= fw) ? PH_IDLE : PH_FHDR;
                                end else begin
                                    value_left_next = len_new[LENGTH_BITS-1:0];
                                    phase_next      = PH_VALUE;
                                end
                            end
                        end
                    end
                    PH_VALUE: begin
                        value_left_next = value_left_reg - LENGTH_BITS'(1);
                        if (value_left_reg <= LENGTH_BITS'(1)) begin
                            value_left_next = '0;
                            field_num_next  = fn_inc;
                            phase_next      = (fn_inc >= fw) ? PH_IDLE : PH_FHDR;
                        end
                    end
                    default: begin
                        if (field_err_reg == ST_OK) trailing_next = 1'b1;
                    end
                endcase
            end

            if (s_frame_end) begin
                if (sat) begin
                    fin = ST_OVERSIZED;
                end else if (byte_count_reg < BC_W'(HDR_SIZE - 1)) begin
                    fin = ST_TRUNC;
                end else if (hdr_flags_next[0]) begin
                    fin = ST_MAGIC;
                end else if (hdr_flags_next[1]) begin
                    fin = ST_VERSION;
                end else if (hdr_flags_next[2]) begin
                    fin = ST_KIND;
                end else if (count_word_next != 16'(fields_reg)) begin
                    fin = ST_COUNT;
                end else if (body_word_next != 32'(pos_m11)) begin
                    fin = ST_BODY_SIZE;
                end else if (field_err_next != ST_OK) begin
                    fin = field_err_next;
                end else if (phase_next != PH_IDLE) begin
                    fin = ST_TRUNC;
                end else if (trailing_next) begin
                    fin = ST_BODY_SIZE;
                end else if (set_mis_next) begin
                    fin = ST_FIELD_SET;
                end
                ent_ctl.has_status = 1'b1;
                ent_ctl.code       = fin;

                byte_count_next  = '0;
                phase_next       = PH_HEADER;
                hdr_flags_next   = '0;
                count_word_next  = '0;
                body_word_next   = '0;
                field_num_next   = '0;
                prev_tag_next    = '0;
                fhb_next         = '0;
                length_word_next = '0;
                value_left_next  = '0;
                field_err_next   = ST_OK;
                set_mis_next     = 1'b0;
                trailing_next    = 1'b0;
                cur_tag_next     = '0;
            end
        end

        q_push = ent_ctl.has_desc || ent_ctl.has_status;
    end

endmodule

/* hw/rtl/tlv_queue.sv */
// Short FIFO of parsed entries between the parser and the output stage.
// Register array with head/tail pointers; depth from tlv_pkg.
module tlv_queue #(
    parameter int unsigned WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             q_valid,
    output logic [WIDTH-1:0] q_data
);
    import tlv_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full    = count_reg == CNT_W'(QUEUE_DEPTH);
    assign q_valid = count_reg != '0;
    assign q_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (count_reg != CNT_W'(QUEUE_DEPTH)))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (count_reg != '0))
        else $error("queue pop while empty");

endmodule

/* hw/rtl/tlv_back.sv */
// Output stage: turns queued entries into result beats, descriptor before status.
// Holds the beat in an output register until taken. Uses tlv_pkg.
module tlv_back #(
    parameter int unsigned LENGTH_BITS = tlv_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_valid,
    input  tlv_pkg::tlv_ctl_t      q_ctl,
    input  logic [LENGTH_BITS-1:0] q_off,
    input  logic [LENGTH_BITS-1:0] q_len,
    output logic                   q_pop,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_is_status,
    output logic [3:0]             m_status,
    output logic [3:0]             m_field_index,
    output logic [7:0]             m_field_tag,
    output logic [LENGTH_BITS-1:0] m_value_offset,
    output logic [LENGTH_BITS-1:0] m_value_length
);
    import tlv_pkg::*;

    logic                   m_valid_reg, m_valid_next;
    logic                   is_status_reg, is_status_next;
    status_t                status_reg, status_next;
    logic [3:0]             idx_reg, idx_next;
    logic [7:0]             tag_reg, tag_next;
    logic [LENGTH_BITS-1:0] off_reg, off_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic                   pend_reg, pend_next;
    status_t                pend_code_reg, pend_code_next;
    logic                   load;

    assign load  = !m_valid_reg || m_ready;
    assign q_pop = load && !pend_reg && q_valid;

    always_comb begin
        m_valid_next   = m_valid_reg;
        is_status_next = is_status_reg;
        status_next    = status_reg;
        idx_next       = idx_reg;
        tag_next       = tag_reg;
        off_next       = off_reg;
        len_next       = len_reg;
        pend_next      = pend_reg;
        pend_code_next = pend_code_reg;
        if (load) begin
            if (pend_reg) begin
                // status that trailed a descriptor on the same byte
                m_valid_next   = 1'b1;
                is_status_next = 1'b1;
                status_next    = pend_code_reg;
                idx_next       = '0;
                tag_next       = '0;
                off_next       = '0;
                len_next       = '0;
                pend_next      = 1'b0;
            end else if (q_valid) begin
                m_valid_next = 1'b1;
                if (q_ctl.has_desc) begin
                    is_status_next = 1'b0;
                    status_next    = ST_OK;
                    idx_next       = q_ctl.idx;
                    tag_next       = q_ctl.tag;
                    off_next       = q_off;
                    len_next       = q_len;
                    pend_next      = q_ctl.has_status;
                    pend_code_next = q_ctl.code;
                end else begin
                    is_status_next = 1'b1;
                    status_next    = q_ctl.code;
                    idx_next       = '0;
                    tag_next       = '0;
                    off_next       = '0;
                    len_next       = '0;
                end
            end else begin
                m_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            pend_reg    <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        is_status_reg <= is_status_next;
        status_reg    <= status_next;
        idx_reg       <= idx_next;
        tag_reg       <= tag_next;
        off_reg       <= off_next;
        len_reg       <= len_next;
        pend_code_reg <= pend_code_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_is_status    = is_status_reg;
    assign m_status       = status_reg;
    assign m_field_index  = idx_reg;
    assign m_field_tag    = tag_reg;
    assign m_value_offset = off_reg;
    assign m_value_length = len_reg;

    a_pend_behind_desc: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> (m_valid_reg && !is_status_reg))
        else $error("pending status without a descriptor beat in front");

    a_pend_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_ready && pend_reg) |=> (m_valid_reg && is_status_reg))
        else $error("pending status not presented after descriptor beat");

endmodule
